// ----- hw/rtl/hst_pkg.sv -----
// Shared types and constants for the 1-D heat stencil time-step block.
// No dependencies; used by hst_stencil and the top level.
package hst_pkg;

   localparam int RATE_W      = 16;   // rate coefficient, unsigned Q0.16
   localparam int FRAC_BITS   = 16;   // fraction bits of the product
   localparam int IP_W        = 5;    // interior point count register
   localparam int INDEX_W     = 5;    // point index fields
   localparam int IN_VALUE_W  = 32;   // value fields on the request side
   localparam int REQ_DATA_W  = 104;  // index + three values, byte padded
   localparam int CSR_INDEX_W = 1;
   localparam int CSR_DATA_W  = 16;
   localparam int PIPE_DEPTH  = 3;    // register stages in the stencil unit
   localparam int ROUND_HALF  = 32768;

   localparam logic [IP_W-1:0] INTERIOR_RESET = 5'd30;

   localparam logic OP_LOAD = 1'b0;
   localparam logic OP_STEP = 1'b1;

   localparam logic [CSR_INDEX_W-1:0] CSR_RATE_COEFF      = 1'b0;
   localparam logic [CSR_INDEX_W-1:0] CSR_INTERIOR_POINTS = 1'b1;

   typedef enum logic {
      STATE_IDLE,
      STATE_RUN
   } state_type;

   typedef enum logic [1:0] {
      KIND_KEEP,
      KIND_LEFT,
      KIND_RIGHT,
      KIND_STENCIL
   } kind_type;

   typedef struct packed {
      logic     advance;
      kind_type kind;
   } stage_ctrl_type;

endpackage

// ----- hw/rtl/heat_stencil_time_step_top.sv -----
// Top level of the 1-D explicit heat-equation time-step block.
// Depends on hst_pkg, hst_cell and hst_stencil.
//
// The grid lives in a ring of GRID_POINTS cells closed through the three
// stages of the stencil unit. A load transfer writes one cell. A step
// transfer rotates the ring GRID_POINTS + 3 times, one position per cycle
// while the result side is not stalled: the stencil unit sees each point
// with its two neighbors as it leaves the head of the chain and feeds the
// new value back into the tail, so after the full turn every cell holds its
// new value again. Results (points 0..n+1) come out of an output register
// in index order as the new values leave the stencil unit; a stalled
// result freezes the whole ring.
module heat_stencil_time_step_top #(
   parameter int GRID_POINTS = 32,
   parameter int VALUE_WIDTH = 32,
   localparam int RSP_W = ((hst_pkg::INDEX_W + VALUE_WIDTH + 7) / 8) * 8
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_tvalid,
   output logic                              req_tready,
   // point_index[4:0], load_value[36:5], left_value[68:37], right_value[100:69]
   input  logic [hst_pkg::REQ_DATA_W-1:0]    req_tdata,
   // op[0]
   input  logic [0:0]                        req_tuser,
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   // out_index[4:0], out_value[VALUE_WIDTH+4:5]
   output logic [RSP_W-1:0]                  rsp_tdata,
   output logic                              rsp_tlast,
   input  logic                              csr_we,
   input  logic [hst_pkg::CSR_INDEX_W-1:0]   csr_index,
   input  logic [hst_pkg::CSR_DATA_W-1:0]    csr_wdata
);

   localparam int CNT_W = $clog2(GRID_POINTS + hst_pkg::PIPE_DEPTH);
   localparam logic [CNT_W-1:0] SHIFT_LAST = CNT_W'(GRID_POINTS + hst_pkg::PIPE_DEPTH - 1);
   localparam int FIT_W = ((VALUE_WIDTH > hst_pkg::IN_VALUE_W) ?
                           VALUE_WIDTH : hst_pkg::IN_VALUE_W) + 1;
   localparam logic [FIT_W-1:0] FIT_MAX =
      {{(FIT_W-VALUE_WIDTH+1){1'b0}}, {(VALUE_WIDTH-1){1'b1}}};
   localparam logic [FIT_W-1:0] FIT_MIN =
      {{(FIT_W-VALUE_WIDTH+1){1'b1}}, {(VALUE_WIDTH-1){1'b0}}};

   // request fields
   logic                                req_op;
   logic [hst_pkg::INDEX_W-1:0]         req_point_index;
   logic [hst_pkg::IN_VALUE_W-1:0]      req_load_value;
   logic [hst_pkg::IN_VALUE_W-1:0]      req_left_value;
   logic [hst_pkg::IN_VALUE_W-1:0]      req_right_value;

   hst_pkg::state_type                  state_ff, state_in;
   logic [CNT_W-1:0]                    shift_ff, shift_in;
   logic [hst_pkg::RATE_W-1:0]          rate_coeff_ff, rate_coeff_in;
   logic [hst_pkg::IP_W-1:0]            interior_points_ff, interior_points_in;
   logic [VALUE_WIDTH-1:0]              left_bound_ff, left_bound_in;
   logic [VALUE_WIDTH-1:0]              right_bound_ff, right_bound_in;
   logic [VALUE_WIDTH-1:0]              prev_ff, prev_in;
   logic                                rsp_valid_ff, rsp_valid_in;
   logic [hst_pkg::INDEX_W-1:0]         rsp_index_ff, rsp_index_in;
   logic [VALUE_WIDTH-1:0]              rsp_value_ff, rsp_value_in;
   logic                                rsp_last_ff, rsp_last_in;

   logic                                req_fire;
   logic                                step_fire;
   logic                                load_fire;
   logic                                running;
   logic                                advance;
   logic                                emit;
   logic [5:0]                          ip_ext;
   logic [5:0]                          n_active;
   logic [CNT_W-1:0]                    n_last;
   logic [CNT_W-1:0]                    t_out;
   logic [CNT_W+hst_pkg::INDEX_W-1:0]   t_out_wide;
   logic [CNT_W+hst_pkg::INDEX_W-1:0]   n_last_wide;
   logic [CNT_W+hst_pkg::INDEX_W-1:0]   load_idx_wide;
   hst_pkg::stage_ctrl_type             stage_ctrl;
   logic [VALUE_WIDTH-1:0]              stencil_result;
   logic [VALUE_WIDTH-1:0]              cell_value [GRID_POINTS];
   logic [GRID_POINTS-1:0]              cell_load;

   function automatic logic [VALUE_WIDTH-1:0] fit_value(
      input logic [hst_pkg::IN_VALUE_W-1:0] x);
      logic signed [FIT_W-1:0] xe;
      xe = {{(FIT_W-hst_pkg::IN_VALUE_W){x[hst_pkg::IN_VALUE_W-1]}}, x};
      if (xe > $signed(FIT_MAX)) begin
         return FIT_MAX[VALUE_WIDTH-1:0];
      end else if (xe < $signed(FIT_MIN)) begin
         return FIT_MIN[VALUE_WIDTH-1:0];
      end else begin
         return xe[VALUE_WIDTH-1:0];
      end
   endfunction

   assign req_op          = req_tuser[0];
   assign req_point_index = req_tdata[4:0];
   assign req_load_value  = req_tdata[36:5];
   assign req_left_value  = req_tdata[68:37];
   assign req_right_value = req_tdata[100:69];

   assign req_fire  = req_tvalid && req_tready;
   assign step_fire = req_fire && (req_op == hst_pkg::OP_STEP);
   assign load_fire = req_fire && (req_op == hst_pkg::OP_LOAD);

   // active interior count, clamped to 1..GRID_POINTS-2
   always_comb begin
      ip_ext = {1'b0, interior_points_ff};
      if (ip_ext == 6'd0) begin
         n_active = 6'd1;
      end else if (ip_ext > 6'(GRID_POINTS - 2)) begin
         n_active = 6'(GRID_POINTS - 2);
      end else begin
         n_active = ip_ext;
      end
      n_last = CNT_W'(n_active + 6'd1);
   end

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         hst_pkg::STATE_IDLE: begin
            if (step_fire) begin
               state_in = hst_pkg::STATE_RUN;
            end
         end
         hst_pkg::STATE_RUN: begin
            if (advance && (shift_ff == SHIFT_LAST)) begin
               state_in = hst_pkg::STATE_IDLE;
            end
         end
         default: state_in = hst_pkg::STATE_IDLE;
      endcase
   end

   // state outputs
   always_comb begin
      req_tready = 1'b0;
      running    = 1'b0;
      case (state_ff)
         hst_pkg::STATE_IDLE: req_tready = 1'b1;
         hst_pkg::STATE_RUN:  running    = 1'b1;
         default: begin
            req_tready = 1'b0;
            running    = 1'b0;
         end
      endcase
   end

   assign advance = running && (!rsp_valid_ff || rsp_tready);

   // stage kind for the point now at the head of the chain
   always_comb begin
      stage_ctrl.advance = advance;
      if (shift_ff == '0) begin
         stage_ctrl.kind = hst_pkg::KIND_LEFT;
      end else if (shift_ff == n_last) begin
         stage_ctrl.kind = hst_pkg::KIND_RIGHT;
      end else if (shift_ff < n_last) begin
         stage_ctrl.kind = hst_pkg::KIND_STENCIL;
      end else begin
         stage_ctrl.kind = hst_pkg::KIND_KEEP;
      end
   end

   // the stencil output lags the head by the pipeline depth
   always_comb begin
      t_out       = shift_ff - CNT_W'(hst_pkg::PIPE_DEPTH);
      t_out_wide  = {{hst_pkg::INDEX_W{1'b0}}, t_out};
      n_last_wide = {{hst_pkg::INDEX_W{1'b0}}, n_last};
      emit = ({1'b0, shift_ff} >= (CNT_W+1)'(hst_pkg::PIPE_DEPTH)) &&
             ({1'b0, shift_ff} <= ({1'b0, n_last} + (CNT_W+1)'(hst_pkg::PIPE_DEPTH)));
   end

   always_comb begin
      shift_in = shift_ff;
      if (step_fire) begin
         shift_in = '0;
      end else if (advance) begin
         shift_in = (shift_ff == SHIFT_LAST) ? '0 : shift_ff + CNT_W'(1);
      end
   end

   always_comb begin
      rate_coeff_in      = rate_coeff_ff;
      interior_points_in = interior_points_ff;
      if (csr_we) begin
         case (csr_index)
            hst_pkg::CSR_RATE_COEFF:      rate_coeff_in = csr_wdata;
            hst_pkg::CSR_INTERIOR_POINTS: interior_points_in = csr_wdata[hst_pkg::IP_W-1:0];
            default: begin
               rate_coeff_in      = rate_coeff_ff;
               interior_points_in = interior_points_ff;
            end
         endcase
      end
   end

   always_comb begin
      left_bound_in  = left_bound_ff;
      right_bound_in = right_bound_ff;
      if (step_fire) begin
         left_bound_in  = fit_value(req_left_value);
         right_bound_in = fit_value(req_right_value);
      end
      prev_in = advance ? cell_value[0] : prev_ff;
   end

   // output register: loads on every ring shift, drains when taken
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_index_in = rsp_index_ff;
      rsp_value_in = rsp_value_ff;
      rsp_last_in  = rsp_last_ff;
      if (advance) begin
         rsp_valid_in = emit;
         rsp_index_in = t_out_wide[hst_pkg::INDEX_W-1:0];
         rsp_value_in = stencil_result;
         rsp_last_in  = (t_out == n_last);
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff           <= hst_pkg::STATE_IDLE;
         shift_ff           <= '0;
         rsp_valid_ff       <= 1'b0;
         rate_coeff_ff      <= '0;
         interior_points_ff <= hst_pkg::INTERIOR_RESET;
      end else begin
         state_ff           <= state_in;
         shift_ff           <= shift_in;
         rsp_valid_ff       <= rsp_valid_in;
         rate_coeff_ff      <= rate_coeff_in;
         interior_points_ff <= interior_points_in;
      end
   end

   always_ff @(posedge clock) begin
      left_bound_ff  <= left_bound_in;
      right_bound_ff <= right_bound_in;
      prev_ff        <= prev_in;
      rsp_index_ff   <= rsp_index_in;
      rsp_value_ff   <= rsp_value_in;
      rsp_last_ff    <= rsp_last_in;
   end

   assign load_idx_wide = {{CNT_W{1'b0}}, req_point_index};

   // cell chain: each cell takes its right neighbor, the tail takes the stencil
   for (genvar k = 0; k < GRID_POINTS; k++) begin : g_cell
      logic [VALUE_WIDTH-1:0] shift_src;

      if (k == GRID_POINTS - 1) begin : g_tail
         assign shift_src = stencil_result;
      end else begin : g_body
         assign shift_src = cell_value[k+1];
      end

      assign cell_load[k] =
         load_fire && (load_idx_wide == (CNT_W+hst_pkg::INDEX_W)'(k));

      hst_cell #(
         .VALUE_WIDTH (VALUE_WIDTH)
      ) u_cell (
         .clock    (clock),
         .reset    (reset),
         .shift_en (advance),
         .load_en  (cell_load[k]),
         .shift_in (shift_src),
         .load_in  (fit_value(req_load_value)),
         .value    (cell_value[k])
      );
   end

   hst_stencil #(
      .VALUE_WIDTH (VALUE_WIDTH)
   ) u_stencil (
      .clock       (clock),
      .ctrl        (stage_ctrl),
      .rate        (rate_coeff_ff),
      .left_pt     (prev_ff),
      .centre_pt   (cell_value[0]),
      .right_pt    (cell_value[1]),
      .left_bound  (left_bound_ff),
      .right_bound (right_bound_ff),
      .result      (stencil_result)
   );

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = RSP_W'({rsp_value_ff, rsp_index_ff});
   assign rsp_tlast  = rsp_last_ff;

   // the ring is at rest whenever no step is in progress
   a_idle_at_rest: assert property (@(posedge clock) disable iff (reset)
      (state_ff == hst_pkg::STATE_IDLE) |-> (shift_ff == '0))
      else $error("shift count not at rest while idle");

   // a step starts a fresh turn of the ring
   a_step_starts: assert property (@(posedge clock) disable iff (reset)
      step_fire |=> (running && (shift_ff == '0)))
      else $error("step transfer did not start a ring turn");

   // the closing result of a run reports the right boundary point
   a_last_index: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_last_ff) |->
         (rsp_index_ff == n_last_wide[hst_pkg::INDEX_W-1:0]))
      else $error("last result does not report the right boundary");

   // nothing leaves the output register unless the ring moved to load it
   a_emit_only_on_shift: assert property (@(posedge clock) disable iff (reset)
      ($rose(rsp_valid_ff)) |-> $past(advance))
      else $error("result appeared without a ring shift");

endmodule

// ----- hw/rtl/hst_cell.sv -----
// One grid cell of the rotating temperature chain.
// Depends on nothing but its neighbors; instantiated by the top level.
module hst_cell #(
   parameter int VALUE_WIDTH = 32
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   shift_en,
   input  logic                   load_en,
   input  logic [VALUE_WIDTH-1:0] shift_in,
   input  logic [VALUE_WIDTH-1:0] load_in,
   output logic [VALUE_WIDTH-1:0] value
);

   logic [VALUE_WIDTH-1:0] value_ff;
   logic [VALUE_WIDTH-1:0] value_in;

   always_comb begin
      value_in = value_ff;
      if (shift_en) begin
         value_in = shift_in;
      end else if (load_en) begin
         value_in = load_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         value_ff <= '0;
      end else begin
         value_ff <= value_in;
      end
   end

   assign value = value_ff;

endmodule

// ----- hw/rtl/hst_stencil.sv -----
// Three-stage stencil unit: difference, rate product, round/add/saturate.
// Depends on hst_pkg; sits in the feedback path of the cell chain.
module hst_stencil #(
   parameter int VALUE_WIDTH = 32
) (
   input  logic                          clock,
   input  hst_pkg::stage_ctrl_type       ctrl,
   input  logic [hst_pkg::RATE_W-1:0]    rate,
   input  logic [VALUE_WIDTH-1:0]        left_pt,
   input  logic [VALUE_WIDTH-1:0]        centre_pt,
   input  logic [VALUE_WIDTH-1:0]        right_pt,
   input  logic [VALUE_WIDTH-1:0]        left_bound,
   input  logic [VALUE_WIDTH-1:0]        right_bound,
   output logic [VALUE_WIDTH-1:0]        result
);

   localparam int DIFF_W = VALUE_WIDTH + 2;
   localparam int SUM_W  = VALUE_WIDTH + 3;
   localparam int PROD_W = VALUE_WIDTH + 3 + hst_pkg::RATE_W;
   localparam logic [SUM_W-1:0] SAT_MAX = {4'b0000, {(VALUE_WIDTH-1){1'b1}}};
   localparam logic [SUM_W-1:0] SAT_MIN = {4'b1111, {(VALUE_WIDTH-1){1'b0}}};

   logic [VALUE_WIDTH-1:0]   a_base_ff, a_base_in;
   logic signed [DIFF_W-1:0] a_diff_ff, a_diff_in;
   logic                     a_stencil_ff, a_stencil_in;
   logic [VALUE_WIDTH-1:0]   b_base_ff;
   logic signed [PROD_W-1:0] b_prod_ff, b_prod_in;
   logic                     b_stencil_ff;
   logic [VALUE_WIDTH-1:0]   c_result_ff, c_result_in;
   logic signed [PROD_W-1:0] biased;
   logic signed [SUM_W-1:0]  rounded;
   logic signed [SUM_W-1:0]  sum;

   // stage A: pick the base value, form left + right - 2*centre
   always_comb begin
      a_diff_in = $signed({{2{left_pt[VALUE_WIDTH-1]}}, left_pt})
                + $signed({{2{right_pt[VALUE_WIDTH-1]}}, right_pt})
                - $signed({centre_pt[VALUE_WIDTH-1], centre_pt, 1'b0});
      a_stencil_in = (ctrl.kind == hst_pkg::KIND_STENCIL);
      case (ctrl.kind)
         hst_pkg::KIND_LEFT:  a_base_in = left_bound;
         hst_pkg::KIND_RIGHT: a_base_in = right_bound;
         default:             a_base_in = centre_pt;
      endcase
   end

   // stage B: r * diff, r is unsigned
   assign b_prod_in = $signed({1'b0, rate}) * a_diff_ff;

   // stage C: round to nearest with ties up, add centre, saturate
   always_comb begin
      biased  = b_prod_ff + PROD_W'(hst_pkg::ROUND_HALF);
      rounded = biased[PROD_W-1:hst_pkg::FRAC_BITS];
      sum     = $signed({{3{b_base_ff[VALUE_WIDTH-1]}}, b_base_ff}) + rounded;
      if (!b_stencil_ff) begin
         c_result_in = b_base_ff;
      end else if (sum > $signed(SAT_MAX)) begin
         c_result_in = SAT_MAX[VALUE_WIDTH-1:0];
      end else if (sum < $signed(SAT_MIN)) begin
         c_result_in = SAT_MIN[VALUE_WIDTH-1:0];
      end else begin
         c_result_in = sum[VALUE_WIDTH-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (ctrl.advance) begin
         a_base_ff    <= a_base_in;
         a_diff_ff    <= a_diff_in;
         a_stencil_ff <= a_stencil_in;
         b_base_ff    <= a_base_ff;
         b_prod_ff    <= b_prod_in;
         b_stencil_ff <= a_stencil_ff;
         c_result_ff  <= c_result_in;
      end
   end

   assign result = c_result_ff;

endmodule
